[rtl/lqs_pkg.sv]
package lqs_pkg;

  // payload of one input transaction
  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] item_value;
  } in_item_t;

  // payload of one result transaction
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] out_value;
    logic [7:0]         position;
  } out_item_t;

  // operation codes
  localparam logic [1:0] OP_ENQ  = 2'd0;
  localparam logic [1:0] OP_DEQ  = 2'd1;
  localparam logic [1:0] OP_SRCH = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // which result the datapath builds
  typedef enum logic [2:0] {
    RES_OK,
    RES_FULL,
    RES_EMPTY,
    RES_DEQ,
    RES_FOUND,
    RES_NOTFOUND
  } res_sel_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEQ,
    S_SRCH
  } lqs_state_t;

  // controller to datapath
  typedef struct packed {
    logic     load;
    logic     enq;
    logic     deq;
    logic     step;
    logic     scan;
    logic     emit;
    res_sel_t res_sel;
  } lqs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic nonempty;
    logic full;
    logic hit;
    logic last;
  } lqs_stat_t;

endpackage

[rtl/lqs_ctrl.sv]
module lqs_ctrl
  import lqs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] operation,
  input  lqs_stat_t  stat,
  output lqs_cmd_t   cmd,
  output logic       busy
);

  lqs_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.res_sel = RES_OK;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (operation)
            OP_ENQ: begin
              cmd.emit = 1'b1;
              if (stat.full) begin
                cmd.res_sel = RES_FULL;
              end else begin
                cmd.enq     = 1'b1;
                cmd.res_sel = RES_OK;
              end
            end
            OP_DEQ: begin
              if (!stat.nonempty) begin
                cmd.emit    = 1'b1;
                cmd.res_sel = RES_EMPTY;
              end else begin
                cmd.load  = 1'b1;
                state_nxt = S_DEQ;
              end
            end
            OP_SRCH: begin
              if (!stat.nonempty) begin
                cmd.emit    = 1'b1;
                cmd.res_sel = RES_EMPTY;
              end else begin
                cmd.load  = 1'b1;
                state_nxt = S_SRCH;
              end
            end
            default: begin
              cmd.emit    = 1'b1;
              cmd.res_sel = RES_OK;
            end
          endcase
        end
      end
      S_DEQ: begin
        cmd.deq     = 1'b1;
        cmd.emit    = 1'b1;
        cmd.res_sel = RES_DEQ;
        state_nxt   = S_IDLE;
      end
      S_SRCH: begin
        cmd.scan = 1'b1;
        if (stat.hit) begin
          cmd.emit    = 1'b1;
          cmd.res_sel = RES_FOUND;
          state_nxt   = S_IDLE;
        end else if (stat.last) begin
          cmd.emit    = 1'b1;
          cmd.res_sel = RES_NOTFOUND;
          state_nxt   = S_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

`ifndef NO_ASSERTIONS
  // a search or dequeue only runs on a held word
  a_busy_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> stat.nonempty)
    else $error("busy on empty queue");
`endif

endmodule

[rtl/lqs_datapath.sv]
module lqs_datapath
  import lqs_pkg::*;
#(
  parameter int DEPTH = 128
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  lqs_cmd_t  cmd,
  output lqs_stat_t stat,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW = (AW + 1 > 8) ? AW + 1 : 8;
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  logic [31:0]   mem [DEPTH];
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic          nonempty_r, nonempty_nxt;
  logic          out_valid_r;
  logic [AW-1:0] cnt_r;
  logic [31:0]   key_r;
  logic [31:0]   rd_data_r;
  out_item_t     out_item_r, out_item_nxt;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] cnt_inc;
  logic [PW-1:0] pos_full;

  assign cnt_inc  = (cnt_r == LAST_SLOT) ? '0 : cnt_r + AW'(1);
  assign rd_addr  = cmd.scan ? cnt_inc : head_r;
  assign wr_addr  = nonempty_r ? tail_r + AW'(1) : '0;
  assign pos_full = PW'(cnt_r) - PW'(head_r) + PW'(1);

  assign stat.nonempty = nonempty_r;
  assign stat.full     = nonempty_r && (tail_r == LAST_SLOT);
  assign stat.hit      = (rd_data_r == key_r);
  assign stat.last     = (cnt_r == tail_r);

  // storage
  always_ff @(posedge clk) begin
    if (cmd.enq) begin
      mem[wr_addr] <= in_item.item_value;
    end
    rd_data_r <= mem[rd_addr];
  end

  // index update
  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    nonempty_nxt = nonempty_r;
    if (cmd.enq) begin
      if (!nonempty_r) begin
        head_nxt     = '0;
        tail_nxt     = '0;
        nonempty_nxt = 1'b1;
      end else begin
        tail_nxt = tail_r + AW'(1);
      end
    end else if (cmd.deq) begin
      if (head_r >= tail_r) begin
        head_nxt     = '0;
        tail_nxt     = '0;
        nonempty_nxt = 1'b0;
      end else begin
        head_nxt = head_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      nonempty_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      nonempty_r  <= nonempty_nxt;
      out_valid_r <= cmd.emit;
    end
  end

  // result payload
  always_comb begin
    out_item_nxt = '0;
    case (cmd.res_sel)
      RES_OK:       out_item_nxt.status = ST_OK;
      RES_FULL:     out_item_nxt.status = ST_FULL;
      RES_EMPTY:    out_item_nxt.status = ST_EMPTY;
      RES_NOTFOUND: out_item_nxt.status = ST_NOTFOUND;
      RES_DEQ: begin
        out_item_nxt.status    = ST_OK;
        out_item_nxt.out_value = rd_data_r;
      end
      RES_FOUND: begin
        out_item_nxt.status    = ST_OK;
        out_item_nxt.out_value = rd_data_r;
        out_item_nxt.position  = pos_full[7:0];
      end
      default: out_item_nxt.status = ST_OK;
    endcase
  end

  // scan pointer, key and result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cnt_r <= head_r;
      key_r <= in_item.item_value;
    end else if (cmd.step) begin
      cnt_r <= cnt_inc;
    end
    if (cmd.emit) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef NO_ASSERTIONS
  // empty queue always sits at slot zero
  a_empty_idx: assert property (@(posedge clk) disable iff (!rst_n)
    !nonempty_r |-> (head_r == '0 && tail_r == '0))
    else $error("indices off zero while empty");

  // head never passes tail
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    nonempty_r |-> (head_r <= tail_r))
    else $error("head beyond tail");

  // a scan stays between head and tail
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan |-> (cnt_r >= head_r && cnt_r <= tail_r))
    else $error("scan outside held words");
`endif

endmodule

[rtl/linear_queue_with_search_top.sv]
// linear array queue of signed 32-bit words with search
//
// input channel: in_item (operation, item_value) is taken as a transaction
// on a rising edge with start high and busy low. operation selects enqueue,
// dequeue or search; the unused code answers ok and changes nothing.
// result channel: one result per input transaction, shown on out_item for
// exactly one cycle while out_valid is high; the receiver cannot stall it.
// enqueue, the unused code and any full or empty answer go straight to the
// result register; dequeue first does one registered memory read, then
// answers from S_DEQ; search visits n entries, n at most DEPTH.
// the search loop reads one stored word a cycle through the single memory
// read port and compares it with the key, so busy stays high while it runs.
// a new transaction may be accepted in the cycle its predecessor's result
// is shown.
// reset (synchronous, rst_n low) empties the queue and drops out_valid;
// storage is not cleared, a stored word only reaches a result once written
module linear_queue_with_search_top
  import lqs_pkg::*;
#(
  parameter int DEPTH = 128
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  // command and status between sequencer and datapath
  lqs_cmd_t  cmd;
  lqs_stat_t stat;
  logic      ctrl_start;

  // sequencer only sees start while idle
  assign ctrl_start = start && !busy;

  lqs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (ctrl_start),
    .operation (in_item.operation),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  // queue storage, indices, scan pointer and result register
  lqs_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

`ifndef NO_ASSERTIONS
  // every result transaction stems from an accepted or running one
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(start && !busy) || $past(busy)))
    else $error("result without transaction");

  // busy only follows an accepted transaction or continues
  a_busy_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy without start");
`endif

endmodule
